/* rtl/core/uart_rx_tx_ring_buffers_macros.svh */
// Assertion macros shared by the serial-port ring buffer RTL.
`ifndef UART_RX_TX_RING_BUFFERS_MACROS_SVH
`define UART_RX_TX_RING_BUFFERS_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define URB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define URB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/uartrb_pkg.sv */
// Shared constants and types of the serial-port ring buffers.
`timescale 1ns / 1ps
`default_nettype none

package uartrb_pkg;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;

  localparam int BYTE_W   = 8;
  localparam int FILL_W   = 8;
  localparam int REQ_W    = 3;
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
  localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

  localparam logic [BYTE_W-1:0] LINE_END_RESET = 8'd10;

  typedef enum logic [REQ_W-1:0] {
    REQ_RX_BYTE    = 3'd0,
    REQ_TX_READY   = 3'd1,
    REQ_HOST_READ  = 3'd2,
    REQ_HOST_WRITE = 3'd3,
    REQ_DISCARD    = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // Result fields, first field in the highest bits.
  typedef struct packed {
    status_t           status;
    logic              line_ready;
    logic [FILL_W-1:0] tx_fill;
    logic [FILL_W-1:0] rx_fill;
    logic              tx_irq_enable;
    logic              send_valid;
    logic [BYTE_W-1:0] send_byte;
    logic              read_valid;
    logic [BYTE_W-1:0] read_byte;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

/* rtl/core/uartrb_cell.sv */
// One byte cell of a compacting FIFO row: loads a new byte or takes its neighbor's.
`timescale 1ns / 1ps
`default_nettype none

module uartrb_cell
  import uartrb_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic              shift,
  input  logic [BYTE_W-1:0] load_byte,
  input  logic [BYTE_W-1:0] neighbor_byte,
  output logic [BYTE_W-1:0] held_byte
);

  always_ff @(posedge clk) begin
    if (load) begin
      held_byte <= load_byte;
    end else if (shift) begin
      held_byte <= neighbor_byte;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/uart_rx_tx_ring_buffers.sv */
// Top level of the serial-port receive and transmit byte buffers.
// A result is registered and presented in the cycle after its input transfer.
// Throughput: one item per cycle while the output is not stalled; each event updates the counters
// and moves the cell rows, and a new item is taken in the cycle the held result transfers.
// Reset: both buffers empty, interrupt enable off, line-end byte 10; the cell
// rows need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "uart_rx_tx_ring_buffers_macros.svh"

module uart_rx_tx_ring_buffers
  import uartrb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [BYTE_W-1:0] s_tdata,      // data_byte
  input  logic [REQ_W-1:0]  s_tuser,      // req_type
  output logic              m_tvalid,
  input  logic              m_tready,
  // From bit 0: read_byte, read_valid, send_byte, send_valid, tx_irq_enable,
  // rx_fill, tx_fill, line_ready, status, zero fill.
  output logic [OUT_W-1:0]  m_tdata,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data
);

  logic [BYTE_W-1:0]   line_end_char;
  logic [RX_CNT_W-1:0] rx_count;
  logic [RX_CNT_W-1:0] rx_count_next;
  logic [RX_CNT_W-1:0] rx_nl_count;
  logic [RX_CNT_W-1:0] rx_nl_count_next;
  logic [TX_CNT_W-1:0] tx_count;
  logic [TX_CNT_W-1:0] tx_count_next;
  logic                tx_irq_on;
  logic                tx_irq_on_next;
  logic                out_valid;
  result_t             out_res;
  result_t             res_next;

  logic [BYTE_W-1:0] rx_byte [RX_DEPTH+1];
  logic [RX_DEPTH:0] rx_mark;
  logic [BYTE_W-1:0] tx_byte [TX_DEPTH+1];

  req_t req;
  logic accept;
  logic rx_push;
  logic rx_pop;
  logic tx_push;
  logic tx_pop;
  logic rx_match;

  assign req      = req_t'(s_tuser);
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign rx_match = (s_tdata == line_end_char);

  assign rx_push = accept && (req == REQ_RX_BYTE) && (rx_count < RX_CNT_W'(RX_DEPTH));
  assign rx_pop  = accept && (req == REQ_HOST_READ) && (rx_count != '0);
  assign tx_push = accept && (req == REQ_HOST_WRITE) && (tx_count < TX_CNT_W'(TX_DEPTH));
  assign tx_pop  = accept && (req == REQ_TX_READY) && (tx_count != '0);

  assign rx_byte[RX_DEPTH] = '0;
  assign rx_mark[RX_DEPTH] = 1'b0;
  assign tx_byte[TX_DEPTH] = '0;

  for (genvar i = 0; i < RX_DEPTH; i++) begin : g_rx
    logic load;
    logic mark;
    assign load = rx_push && (rx_count == RX_CNT_W'(i));
    uartrb_cell u_cell (
      .clk           (clk),
      .load          (load),
      .shift         (rx_pop),
      .load_byte     (s_tdata),
      .neighbor_byte (rx_byte[i+1]),
      .held_byte     (rx_byte[i])
    );
    always_ff @(posedge clk) begin
      if (load) begin
        mark <= rx_match;
      end else if (rx_pop) begin
        mark <= rx_mark[i+1];
      end
    end
    assign rx_mark[i] = mark;
  end

  for (genvar i = 0; i < TX_DEPTH; i++) begin : g_tx
    logic load;
    assign load = tx_push && (tx_count == TX_CNT_W'(i));
    uartrb_cell u_cell (
      .clk           (clk),
      .load          (load),
      .shift         (tx_pop),
      .load_byte     (s_tdata),
      .neighbor_byte (tx_byte[i+1]),
      .held_byte     (tx_byte[i])
    );
  end

  always_comb begin
    rx_count_next    = rx_count;
    rx_nl_count_next = rx_nl_count;
    tx_count_next    = tx_count;
    tx_irq_on_next   = tx_irq_on;
    res_next         = '0;
    res_next.status  = STATUS_OK;
    case (req)
      REQ_RX_BYTE: begin
        if (rx_push) begin
          rx_count_next = rx_count + 1'b1;
          if (rx_match) begin
            rx_nl_count_next = rx_nl_count + 1'b1;
          end
        end else begin
          res_next.status = STATUS_FULL;
        end
      end
      REQ_TX_READY: begin
        if (tx_pop) begin
          res_next.send_byte  = tx_byte[0];
          res_next.send_valid = 1'b1;
          tx_count_next       = tx_count - 1'b1;
        end else begin
          tx_irq_on_next  = 1'b0;
          res_next.status = STATUS_EMPTY;
        end
      end
      REQ_HOST_READ: begin
        if (rx_pop) begin
          res_next.read_byte  = rx_byte[0];
          res_next.read_valid = 1'b1;
          rx_count_next       = rx_count - 1'b1;
          if (rx_mark[0] && (rx_nl_count != '0)) begin
            rx_nl_count_next = rx_nl_count - 1'b1;
          end
        end else begin
          res_next.status = STATUS_EMPTY;
        end
      end
      REQ_HOST_WRITE: begin
        if (tx_push) begin
          tx_count_next = tx_count + 1'b1;
        end else begin
          res_next.status = STATUS_FULL;
        end
        tx_irq_on_next = 1'b1;
      end
      REQ_DISCARD: begin
        rx_count_next    = '0;
        rx_nl_count_next = '0;
      end
      default: begin
      end
    endcase
    res_next.tx_irq_enable = tx_irq_on_next;
    res_next.rx_fill       = FILL_W'(rx_count_next);
    res_next.tx_fill       = FILL_W'(tx_count_next);
    res_next.line_ready    = (rx_nl_count_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_end_char <= LINE_END_RESET;
    end else if (cfg_wr_en) begin
      line_end_char <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count    <= '0;
      rx_nl_count <= '0;
      tx_count    <= '0;
      tx_irq_on   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        rx_count    <= rx_count_next;
        rx_nl_count <= rx_nl_count_next;
        tx_count    <= tx_count_next;
        tx_irq_on   <= tx_irq_on_next;
        out_valid   <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_res);

  `URB_ASSERT_SAME(a_nl_within_fill, 1'b1, rx_nl_count <= rx_count, "line-end count exceeds receive fill")
  `URB_ASSERT_NEXT(a_discard_clears, accept && (req == REQ_DISCARD), (rx_count == '0) && (rx_nl_count == '0), "discard left receive state behind")
  `URB_ASSERT_NEXT(a_empty_read, rx_pop == 1'b0 && accept && (req == REQ_HOST_READ), (out_res.status == STATUS_EMPTY) && !out_res.read_valid, "empty host read returned a byte")
  `URB_ASSERT_NEXT(a_write_sets_irq, accept && (req == REQ_HOST_WRITE), tx_irq_on && out_res.tx_irq_enable, "host write did not set interrupt enable")

endmodule

`default_nettype wire
